// File: hdl/kbs_pkg.sv
// ----------------------------------------------------------------------------
// kbs_pkg: shared types and constants for the kinematic body step block
// Action, mode and register codes, unit request and status types, and the saturating helper.
// ----------------------------------------------------------------------------
package kbs_pkg;
	localparam int MW = 33;
	localparam int PW = 66;

	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_SET_ACC = 2'd1;
	localparam logic [1:0] ACT_SET_POS = 2'd2;
	localparam logic [1:0] ACT_SET_VEL = 2'd3;

	localparam logic MODE_DIV  = 1'b0;
	localparam logic MODE_SQRT = 1'b1;

	localparam logic [1:0] REG_TERM_SPEED = 2'd0;
	localparam logic [1:0] REG_RAMP_TIME  = 2'd1;
	localparam logic [1:0] REG_DRAG_RATE  = 2'd2;

	typedef struct packed {
		logic       start;
		logic       mode;
		logic [5:0] steps;
	} kbs_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} kbs_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// File: hdl/kbs_in_if.sv
// ----------------------------------------------------------------------------
// kbs_in_if: input request channel
// Valid/ready channel that carries one action request.
// ----------------------------------------------------------------------------
interface kbs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [19:0]        step_dt;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic               continuous;

	modport source(output valid, action, step_dt, value_x, value_y, continuous,
		input ready);
	modport sink(input valid, action, step_dt, value_x, value_y, continuous,
		output ready);
endinterface

// File: hdl/kbs_out_if.sv
// ----------------------------------------------------------------------------
// kbs_out_if: result channel
// Valid/ready channel that carries the position and velocity.
// ----------------------------------------------------------------------------
interface kbs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;

	modport source(output valid, pos_x, pos_y, vel_x, vel_y, input ready);
	modport sink(input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// File: hdl/kbs_cfg_if.sv
// ----------------------------------------------------------------------------
// kbs_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface kbs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/kbs_mul.sv
// ----------------------------------------------------------------------------
// kbs_mul: shared registered multiplier
// Signed 33 by 33 multiply with the product registered.
// ----------------------------------------------------------------------------
module kbs_mul (
	input  logic                           clk,
	input  logic signed [kbs_pkg::MW-1:0]  a,
	input  logic signed [kbs_pkg::MW-1:0]  b,
	output logic signed [kbs_pkg::PW-1:0]  prod_q
);
	import kbs_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PW'(a) * PW'(b);
	end
endmodule

// File: hdl/kbs_divsqrt.sv
// ----------------------------------------------------------------------------
// kbs_divsqrt: iterative divider and square root
// Restoring division one quotient bit a cycle, or integer square root of a
// 64-bit value two bits a cycle, sharing one counter and result register.
// ----------------------------------------------------------------------------
module kbs_divsqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  kbs_pkg::kbs_ctl_t ctl,
	input  logic [63:0]       num,
	input  logic [31:0]       den,
	output kbs_pkg::kbs_sts_t sts,
	output logic [31:0]       result
);
	import kbs_pkg::*;

	logic        busy_q, done_q, mode_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q, den_q;
	logic [63:0] sh_q, res_q, bit_q;
	logic [32:0] trial;
	logic        ge;
	logic [63:0] sum;
	logic        sq_ge;

	assign trial = {rem_q, sh_q[63]};
	assign ge    = trial >= {1'b0, den_q};
	assign sum   = res_q + bit_q;
	assign sq_ge = sh_q >= sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (ctl.mode == MODE_SQRT) ? 6'd32 : ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.mode;
			den_q  <= den;
			res_q  <= '0;
			bit_q  <= 64'd1 << 62;
			if (ctl.mode == MODE_SQRT) begin
				sh_q  <= num;
				rem_q <= '0;
			end else begin
				// The caller guarantees the leading part is below the divisor.
				rem_q <= 32'(num >> ctl.steps);
				sh_q  <= num << (7'd64 - 7'(ctl.steps));
			end
		end else if (busy_q) begin
			if (mode_q == MODE_SQRT) begin
				if (sq_ge) begin
					sh_q  <= sh_q - sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				rem_q <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
				res_q <= {res_q[62:0], ge};
				sh_q  <= sh_q << 1;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = res_q[31:0];
endmodule

// File: hdl/kinematic_body_step_top.sv
// A set request is registered and passes to the finish state, which registers the
// result valid once the output is free. A tick applies any set acceleration, after a
// ramp-factor divide while still ramping in, skips drag when the velocity is zero after
// the ramp step, and runs a root and a per-component divide when the speed clamp fires.
// One request is in work at a time; the next is taken once the block is idle after the
// result is registered; a stalled result holds it. Reset clears motion, loads defaults.
// ----------------------------------------------------------------------------
// kinematic_body_step_top: 2D Euler integrator with ramp, drag and speed clamp
// Sequencer that drives a shared multiplier and a shared divide/root unit.
// ----------------------------------------------------------------------------
module kinematic_body_step_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	kbs_in_if.sink    req,
	kbs_out_if.source rsp,
	kbs_cfg_if.sink   cfg
);
	import kbs_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int MIN_RAW = ((1 << F) + 500) / 1000;
	localparam int MIN_TIME = (MIN_RAW > 0) ? MIN_RAW : 1;
	localparam logic [F:0] ONE = (F+1)'(1) << F;
	localparam logic [F+2:0] THREE = (F+3)'(3) << F;

	localparam logic [4:0] S_IDLE = 5'd0,  S_START = 5'd1, S_RDIV = 5'd2,
		S_S2 = 5'd3, S_S3 = 5'd4, S_S4 = 5'd5, S_S5 = 5'd6, S_S6 = 5'd7,
		S_DRAG0 = 5'd8, S_D1 = 5'd9, S_D2 = 5'd10, S_D3 = 5'd11,
		S_CL0 = 5'd12, S_CL1 = 5'd13, S_CL2 = 5'd14, S_CL3 = 5'd15,
		S_SQ = 5'd16, S_CM = 5'd17, S_CS = 5'd18, S_CD = 5'd19,
		S_POS0 = 5'd20, S_POS1 = 5'd21, S_POS2 = 5'd22, S_FIN = 5'd23;

	logic [4:0]         state_q;
	logic [30:0]        ts_q;
	logic [19:0]        rt_q;
	logic [23:0]        dr_q;
	logic signed [31:0] px_q, py_q, vx_q, vy_q, ax_q, ay_q;
	logic               held_q;
	logic [31:0]        elapsed_q;
	logic [19:0]        dt_q;
	logic [F:0]         s_q, sm_q;
	logic [30:0]        f_q;
	logic [63:0]        acc_q;
	logic [31:0]        len_q;
	logic               cidx_q, sign_q, ovalid_q;
	logic signed [31:0] opx_q, opy_q, ovx_q, ovy_q;

	logic signed [MW-1:0] ma, mb;
	logic signed [PW-1:0] prod_q;
	kbs_ctl_t             ctl;
	kbs_sts_t             sts;
	logic [63:0]          dnum;
	logic [31:0]          dden, dres;

	logic [32:0]          e_sum;
	logic [31:0]          e_sat, rt_eff;
	logic [23:0]          dr_eff;
	logic                 acc_nz, vel_nz, fin_go;
	logic [63-F:0]        f_raw;
	logic [30:0]          f_cap;
	logic signed [31:0]   vsel;
	logic [63:0]          mag;
	logic signed [PW-1:0] scaled;

	assign e_sum  = 33'(elapsed_q) + 33'(dt_q);
	assign e_sat  = e_sum[32] ? 32'hffffffff : e_sum[31:0];
	assign rt_eff = (rt_q != '0) ? 32'(rt_q) : 32'(MIN_TIME);
	assign dr_eff = (dr_q != '0) ? dr_q : 24'(MIN_TIME);
	assign acc_nz = (ax_q != '0) || (ay_q != '0);
	assign vel_nz = (vx_q != '0) || (vy_q != '0);
	assign f_raw  = prod_q[63:F];
	assign f_cap  = (f_raw > (64-F)'(31'h7fffffff)) ? 31'h7fffffff : f_raw[30:0];
	assign vsel   = cidx_q ? vy_q : vx_q;
	assign mag    = prod_q[PW-1] ? 64'(-prod_q) : prod_q[63:0];
	assign scaled = prod_q >>> F;
	assign fin_go = (state_q == S_FIN) && (!ovalid_q || rsp.ready);

	kbs_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod_q(prod_q));

	kbs_divsqrt u_div (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .num(dnum), .den(dden),
		.sts(sts), .result(dres)
	);

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_S2: begin ma = MW'(s_q); mb = MW'(s_q); end
			S_S3: begin ma = MW'(prod_q[2*F:F]); mb = MW'(THREE - {s_q, 1'b0}); end
			S_S4: begin ma = MW'(ax_q); mb = MW'(prod_q[2*F:F]); end
			S_S5: begin ma = MW'(ay_q); mb = MW'(sm_q); end
			S_DRAG0: begin ma = MW'(dr_eff); mb = MW'(dt_q); end
			S_D1: begin ma = MW'(vx_q); mb = MW'(f_cap); end
			S_D2: begin ma = MW'(vy_q); mb = MW'(f_q); end
			S_CL0: begin ma = MW'(vx_q); mb = MW'(vx_q); end
			S_CL1: begin ma = MW'(vy_q); mb = MW'(vy_q); end
			S_CL2: begin ma = MW'(ts_q); mb = MW'(ts_q); end
			S_CM: begin ma = MW'(vsel); mb = MW'(ts_q); end
			S_POS0: begin ma = MW'(vx_q); mb = MW'(dt_q); end
			S_POS1: begin ma = MW'(vy_q); mb = MW'(dt_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_comb begin
		ctl.start = 1'b0;
		ctl.mode  = MODE_DIV;
		ctl.steps = 6'(F);
		dnum      = 64'(e_sat) << F;
		dden      = rt_eff;
		case (state_q)
			S_START: ctl.start = acc_nz && (e_sat < rt_eff);
			S_CL3: begin
				ctl.start = acc_q > prod_q[63:0];
				ctl.mode  = MODE_SQRT;
				dnum      = acc_q;
			end
			S_CS: begin
				ctl.start = 1'b1;
				ctl.steps = 6'd31;
				dnum      = mag;
				dden      = len_q;
			end
			default: ctl.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ts_q      <= 31'd65536000;
			rt_q      <= 20'd65536;
			dr_q      <= 24'd65536;
			px_q      <= '0;
			py_q      <= '0;
			vx_q      <= '0;
			vy_q      <= '0;
			ax_q      <= '0;
			ay_q      <= '0;
			held_q    <= 1'b0;
			elapsed_q <= '0;
			ovalid_q  <= 1'b0;
			cidx_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_TERM_SPEED: ts_q <= cfg.data[30:0];
					REG_RAMP_TIME:  rt_q <= cfg.data[19:0];
					REG_DRAG_RATE:  dr_q <= cfg.data[23:0];
					default: ;
				endcase
			end
			if (fin_go) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (req.valid) begin
					case (req.action)
						ACT_TICK: state_q <= S_START;
						ACT_SET_ACC: begin
							ax_q    <= req.value_x;
							ay_q    <= req.value_y;
							held_q  <= req.continuous;
							state_q <= S_FIN;
						end
						ACT_SET_POS: begin
							px_q    <= req.value_x;
							py_q    <= req.value_y;
							state_q <= S_FIN;
						end
						default: begin
							vx_q    <= req.value_x;
							vy_q    <= req.value_y;
							state_q <= S_FIN;
						end
					endcase
				end
				S_START: begin
					if (acc_nz) begin
						elapsed_q <= e_sat;
						state_q   <= (e_sat < rt_eff) ? S_RDIV : S_S2;
					end else begin
						state_q <= S_DRAG0;
					end
				end
				S_RDIV: if (sts.done) state_q <= S_S2;
				S_S2: state_q <= S_S3;
				S_S3: state_q <= S_S4;
				S_S4: state_q <= S_S5;
				S_S5: begin
					vx_q    <= sat32(PW'(vx_q) + scaled);
					state_q <= S_S6;
				end
				S_S6: begin
					vy_q    <= sat32(PW'(vy_q) + scaled);
					state_q <= S_DRAG0;
				end
				S_DRAG0: state_q <= vel_nz ? S_D1 : S_CL0;
				S_D1: state_q <= S_D2;
				S_D2: begin
					vx_q    <= sat32(PW'(vx_q) - scaled);
					state_q <= S_D3;
				end
				S_D3: begin
					vy_q    <= sat32(PW'(vy_q) - scaled);
					state_q <= S_CL0;
				end
				S_CL0: state_q <= S_CL1;
				S_CL1: state_q <= S_CL2;
				S_CL2: state_q <= S_CL3;
				S_CL3: begin
					cidx_q  <= 1'b0;
					state_q <= (acc_q > prod_q[63:0]) ? S_SQ : S_POS0;
				end
				S_SQ: if (sts.done) state_q <= S_CM;
				S_CM: state_q <= S_CS;
				S_CS: state_q <= S_CD;
				S_CD: if (sts.done) begin
					// The scaled magnitude never exceeds the terminal speed.
					if (cidx_q) begin
						vy_q    <= sign_q ? -$signed(dres) : $signed(dres);
						state_q <= S_POS0;
					end else begin
						vx_q    <= sign_q ? -$signed(dres) : $signed(dres);
						cidx_q  <= 1'b1;
						state_q <= S_CM;
					end
				end
				S_POS0: state_q <= S_POS1;
				S_POS1: begin
					px_q    <= sat32(PW'(px_q) + scaled);
					state_q <= S_POS2;
				end
				S_POS2: begin
					py_q <= sat32(PW'(py_q) + scaled);
					if (!held_q) begin
						ax_q <= '0;
						ay_q <= '0;
					end
					state_q <= S_FIN;
				end
				S_FIN: if (fin_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) dt_q <= req.step_dt;
		if (state_q == S_START) s_q <= ONE;
		if (state_q == S_RDIV && sts.done) s_q <= dres[F:0];
		if (state_q == S_S4) sm_q <= prod_q[2*F:F];
		if (state_q == S_D1) f_q <= f_cap;
		if (state_q == S_CL1) acc_q <= prod_q[63:0];
		if (state_q == S_CL2) acc_q <= acc_q + prod_q[63:0];
		if (state_q == S_SQ && sts.done) len_q <= dres;
		if (state_q == S_CS) sign_q <= prod_q[PW-1];
		if (fin_go) begin
			opx_q <= px_q;
			opy_q <= py_q;
			ovx_q <= vx_q;
			ovy_q <= vy_q;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = ovalid_q;
	assign rsp.pos_x = opx_q;
	assign rsp.pos_y = opy_q;
	assign rsp.vel_x = ovx_q;
	assign rsp.vel_y = ovy_q;

	a_unit_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> (state_q == S_RDIV || state_q == S_SQ || state_q == S_CD))
		else $error("divide/root unit busy outside a waiting state");
	a_fin_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> rsp.valid)
		else $error("finished request not presented");
	a_accel_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POS2 && !held_q) |=> (ax_q == '0 && ay_q == '0))
		else $error("acceleration not cleared after tick");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second request taken while one is in work");
endmodule
